// ===== rtl/ncc_pkg.sv =====
package ncc_pkg;

   // Table geometry
   localparam int unsigned TABLE_SLOTS = 64;
   localparam int unsigned VECTOR_DIMS = 5;
   localparam int unsigned LABEL_COUNT = 16;

   // Field widths fixed by the interface
   localparam int unsigned IN_FIELDS   = 5;
   localparam int unsigned ELEM_W      = 16;
   localparam int unsigned LABEL_W     = 4;
   localparam int unsigned SLOT_FLD_W  = 6;
   localparam int unsigned DIST_W      = 35;

   // Derived widths
   localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int unsigned SQ_W   = 2 * ELEM_W;

   // Request action codes
   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_CLEAR = 2'd2
   } ncc_action_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } ncc_state_type;

   typedef logic [VECTOR_DIMS-1:0][ELEM_W-1:0] ncc_vec_type;

   // One table row: label plus centroid elements
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      ncc_vec_type        vals;
   } ncc_row_type;

   // Controller to datapath
   typedef struct packed {
      logic              start;
      logic              load_wr;
      logic              clear_all;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_slot;
      logic              load_out;
   } ncc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } ncc_status_type;

endpackage

// ===== rtl/nearest_centroid_classifier.sv =====
// Nearest-centroid classifier.
//
// Request channel (req_*): one transaction per action. A load writes the
// centroid and label of one slot, a clear invalidates every slot, and a
// query searches all valid slots for the smallest squared distance. Loads,
// clears and the unused action code give no response transaction.
// A query gives exactly one response transaction (rsp_*) with the found
// flag, the nearest label and its squared distance; ties keep the lowest slot.
//
// A query reads one table slot per cycle from the centroid memory, then
// drains a three-stage distance pipeline, which is shorter when the last
// slots are empty. req_stall is high while a query is in flight, until its
// result is loaded into the output register.
//
// A response waits in the output register while rsp_stall is high; a
// finished query waits until the register frees. Reset clears every
// slot valid bit and drops any pending response; centroid contents are
// left as they are and need no clearing pass.
module nearest_centroid_classifier
   import ncc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   input  logic [SLOT_FLD_W-1:0] req_slot,
   input  logic [LABEL_W-1:0]    req_class_label,
   input  logic signed [15:0]    req_elem_0,
   input  logic signed [15:0]    req_elem_1,
   input  logic signed [15:0]    req_elem_2,
   input  logic signed [15:0]    req_elem_3,
   input  logic signed [15:0]    req_elem_4,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic [LABEL_W-1:0]    rsp_best_class,
   output logic [DIST_W-1:0]     rsp_best_distance
);

   ncc_cmd_type    cmd;
   ncc_status_type status;
   ncc_vec_type    req_vec;
   logic [ELEM_W-1:0] in_elems [IN_FIELDS];

   assign in_elems[0] = req_elem_0;
   assign in_elems[1] = req_elem_1;
   assign in_elems[2] = req_elem_2;
   assign in_elems[3] = req_elem_3;
   assign in_elems[4] = req_elem_4;

   // Dimensions beyond the input fields read as zero
   always_comb begin
      for (int d = 0; d < VECTOR_DIMS; d++) begin
         if (d < IN_FIELDS) req_vec[d] = in_elems[d];
         else req_vec[d] = '0;
      end
   end

   ncc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   ncc_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_slot          (req_slot),
      .req_class_label   (req_class_label),
      .req_vec           (req_vec),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_best_class    (rsp_best_class),
      .rsp_best_distance (rsp_best_distance)
   );

endmodule

// ===== rtl/ncc_ctrl.sv =====
module ncc_ctrl
   import ncc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_action,
   output logic           req_stall,
   input  ncc_status_type status,
   output ncc_cmd_type    cmd
);

   ncc_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              req_take;
   logic              last_slot;

   assign req_take  = (state_ff == ST_IDLE) && req_valid;
   assign last_slot = (cnt_ff == SLOT_W'(TABLE_SLOTS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_action == ACT_QUERY)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last_slot) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Slot counter advances once per scan cycle
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_SCAN) cnt_in = cnt_ff + SLOT_W'(1);
      else cnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Outputs
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      cmd           = '0;
      cmd.rd_slot   = cnt_ff;
      cmd.rd_en     = (state_ff == ST_SCAN);
      cmd.load_out  = (state_ff == ST_DONE) && status.out_free;
      if (req_take) begin
         case (req_action)
            ACT_LOAD:  cmd.load_wr   = 1'b1;
            ACT_QUERY: cmd.start     = 1'b1;
            ACT_CLEAR: cmd.clear_all = 1'b1;
            default:   cmd.start     = 1'b0;
         endcase
      end
   end

endmodule

// ===== rtl/ncc_datapath.sv =====
module ncc_datapath
   import ncc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ncc_cmd_type           cmd,
   output ncc_status_type        status,
   input  logic [SLOT_FLD_W-1:0] req_slot,
   input  logic [LABEL_W-1:0]    req_class_label,
   input  ncc_vec_type           req_vec,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic [LABEL_W-1:0]    rsp_best_class,
   output logic [DIST_W-1:0]     rsp_best_distance
);

   ncc_row_type            centroid_mem [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] slot_valid_ff;
   ncc_vec_type            query_ff;

   ncc_row_type            row_ff;
   logic                   s1_vld_ff, s1_hit_ff;
   logic [SQ_W-1:0]        sq_ff [VECTOR_DIMS];
   logic [SQ_W-1:0]        sq_in [VECTOR_DIMS];
   logic                   s2_vld_ff;
   logic [LABEL_W-1:0]     s2_label_ff;
   logic [DIST_W-1:0]      dist_ff, dist_in;
   logic                   s3_vld_ff;
   logic [LABEL_W-1:0]     s3_label_ff;

   logic                   best_found_ff;
   logic [LABEL_W-1:0]     best_label_ff;
   logic [DIST_W-1:0]      best_dist_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_found_ff;
   logic [LABEL_W-1:0]     rsp_class_ff;
   logic [DIST_W-1:0]      rsp_dist_ff;

   logic                   slot_ok;
   logic [SLOT_W-1:0]      wr_addr;

   assign slot_ok = (32'(req_slot) < TABLE_SLOTS);
   assign wr_addr = SLOT_W'(req_slot);

   // Centroid table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_wr && slot_ok) centroid_mem[wr_addr] <= {req_class_label, req_vec};
      if (cmd.rd_en) row_ff <= centroid_mem[cmd.rd_slot];
   end

   // Slot valid bits
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) slot_valid_ff <= '0;
      else if (cmd.load_wr && slot_ok) slot_valid_ff[wr_addr] <= 1'b1;
   end

   // Query vector held for the whole scan
   always_ff @(posedge clock) begin
      if (cmd.start) query_ff <= req_vec;
   end

   // Per-element squared difference
   always_comb begin
      logic signed [ELEM_W:0]     diff;
      logic signed [2*ELEM_W+1:0] prod;
      for (int d = 0; d < VECTOR_DIMS; d++) begin
         diff     = $signed({query_ff[d][ELEM_W-1], query_ff[d]})
                  - $signed({row_ff.vals[d][ELEM_W-1], row_ff.vals[d]});
         prod     = diff * diff;
         sq_in[d] = prod[SQ_W-1:0];
      end
   end

   // Sum of squares
   always_comb begin
      dist_in = '0;
      for (int d = 0; d < VECTOR_DIMS; d++) dist_in = dist_in + DIST_W'(sq_ff[d]);
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      s1_hit_ff   <= slot_valid_ff[cmd.rd_slot];
      sq_ff       <= sq_in;
      s2_label_ff <= row_ff.label;
      dist_ff     <= dist_in;
      s3_label_ff <= s2_label_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.rd_en;
         s2_vld_ff <= s1_vld_ff && s1_hit_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // Running best; strict compare keeps the lowest slot on ties
   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         best_found_ff <= 1'b0;
         best_label_ff <= '0;
         best_dist_ff  <= '0;
      end else if (s3_vld_ff && (!best_found_ff || (dist_ff < best_dist_ff))) begin
         best_found_ff <= 1'b1;
         best_label_ff <= s3_label_ff;
         best_dist_ff  <= dist_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.load_out) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_found_ff <= best_found_ff;
         rsp_class_ff <= best_label_ff;
         rsp_dist_ff  <= best_dist_ff;
      end
   end

   assign status.pipe_busy = s1_vld_ff || s2_vld_ff || s3_vld_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_best_class    = rsp_class_ff;
   assign rsp_best_distance = rsp_dist_ff;

endmodule

// ===== rtl/ncc_checker.sv =====
module ncc_checker
   import ncc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [1:0]            req_action,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_found,
   input logic [LABEL_W-1:0]    rsp_best_class,
   input logic [DIST_W-1:0]     rsp_best_distance
);

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // An empty-table response carries zero label and distance
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_best_class == '0) && (rsp_best_distance == '0))
      else $error("not-found response with nonzero payload");

   // A taken query blocks further requests while it scans
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_QUERY) |=> req_stall)
      else $error("request taken during query scan");

   // Reset leaves no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind nearest_centroid_classifier ncc_checker u_ncc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_action        (req_action),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_found         (rsp_found),
   .rsp_best_class    (rsp_best_class),
   .rsp_best_distance (rsp_best_distance)
);

// ===== test/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ncc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_200_000;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned MAX_REPORTS  = 200;
   localparam logic [1:0]  ACT_UNUSED   = 2'd3;

   typedef struct packed {
      logic               found;
      logic [LABEL_W-1:0] best_class;
      logic [DIST_W-1:0]  best_distance;
   } match_type;

   // DUT ports, all known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_action = ACT_LOAD;
   logic [SLOT_FLD_W-1:0] req_slot = '0;
   logic [LABEL_W-1:0]    req_class_label = '0;
   logic signed [15:0]    req_elem_0 = '0;
   logic signed [15:0]    req_elem_1 = '0;
   logic signed [15:0]    req_elem_2 = '0;
   logic signed [15:0]    req_elem_3 = '0;
   logic signed [15:0]    req_elem_4 = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_found;
   logic [LABEL_W-1:0]    rsp_best_class;
   logic [DIST_W-1:0]     rsp_best_distance;

   // Shadow copy of the centroid table
   ncc_vec_type        cent_vals  [TABLE_SLOTS];
   logic [LABEL_W-1:0] cent_label [TABLE_SLOTS];
   logic               slot_live  [TABLE_SLOTS];

   match_type   pending_matches [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned gap_max = 0;
   int unsigned stall_pct = 0;
   int unsigned burst_left = 0;
   int unsigned stall_run = 0;
   logic        stall_now = 1'b0;

   always #4 clock = ~clock;

   nearest_centroid_classifier dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_slot          (req_slot),
      .req_class_label   (req_class_label),
      .req_elem_0        (req_elem_0),
      .req_elem_1        (req_elem_1),
      .req_elem_2        (req_elem_2),
      .req_elem_3        (req_elem_3),
      .req_elem_4        (req_elem_4),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_best_class    (rsp_best_class),
      .rsp_best_distance (rsp_best_distance)
   );

   // Nearest live centroid by squared distance; the first slot wins a tie
   function automatic match_type nearest_match(ncc_vec_type q);
      match_type m;
      longint    diff;
      longint    acc;
      m = '0;
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         if (!slot_live[s]) continue;
         acc = 0;
         for (int d = 0; d < VECTOR_DIMS; d++) begin
            diff = longint'($signed(q[d])) - longint'($signed(cent_vals[s][d]));
            acc += diff * diff;
         end
         if (!m.found || acc < m.best_distance) begin
            m.found         = 1'b1;
            m.best_distance = acc[DIST_W-1:0];
            m.best_class    = cent_label[s];
         end
      end
      return m;
   endfunction

   // Element values: extremes, small magnitudes, full range
   function automatic logic [ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return ELEM_W'($urandom_range(0, 511) - 256);
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   function automatic ncc_vec_type rand_vec();
      ncc_vec_type v;
      for (int d = 0; d < VECTOR_DIMS; d++) v[d] = rand_elem();
      return v;
   endfunction

   function automatic ncc_vec_type fill_vec(logic [ELEM_W-1:0] e);
      return {VECTOR_DIMS{e}};
   endfunction

   // Small random offset around a centroid, wrapping at 16 bits
   function automatic ncc_vec_type near_vec(ncc_vec_type base);
      ncc_vec_type v;
      for (int d = 0; d < VECTOR_DIMS; d++)
         v[d] = base[d] + ELEM_W'($urandom_range(0, 63) - 32);
      return v;
   endfunction

   // A few random probes for a live slot, -1 if none hit
   function automatic int find_live();
      int s;
      for (int i = 0; i < 12; i++) begin
         s = $urandom_range(0, TABLE_SLOTS - 1);
         if (slot_live[s]) return s;
      end
      return -1;
   endfunction

   // Send one transaction, with burst gaps, and update the shadow table
   task automatic send_item(input logic [1:0] act, input logic [SLOT_FLD_W-1:0] slot,
                            input logic [LABEL_W-1:0] lbl, input ncc_vec_type v);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_action      <= act;
      req_slot        <= slot;
      req_class_label <= lbl;
      req_elem_0      <= v[0];
      req_elem_1      <= v[1];
      req_elem_2      <= v[2];
      req_elem_3      <= v[3];
      req_elem_4      <= v[4];
      do @(posedge clock); while (req_stall !== 1'b0);
      // transaction taken at this edge
      case (act)
         ACT_LOAD: begin
            if (slot < TABLE_SLOTS) begin
               cent_vals[slot]  = v;
               cent_label[slot] = lbl;
               slot_live[slot]  = 1'b1;
            end
         end
         ACT_QUERY: pending_matches = {pending_matches, nearest_match(v)};
         ACT_CLEAR: foreach (slot_live[s]) slot_live[s] = 1'b0;
         default: ;
      endcase
      if (act != ACT_UNUSED) items_sent++;
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
   endtask

   // Receiver stall pattern: runs of random length, stalled with stall_pct odds
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_run = $urandom_range(1, 16);
         stall_now = ($urandom_range(0, 99) < stall_pct);
      end
      stall_run--;
      rsp_stall <= stall_now;
   end

   // Response checker
   always @(posedge clock) begin
      match_type want;
      if (!reset && rsp_valid !== 1'b0 && !rsp_stall) begin
         if (pending_matches.size() == 0) begin
            report_mismatch("unexpected response valid", 64'd0, 64'(rsp_valid));
         end else begin
            want = pending_matches.pop_front();
            if (rsp_found !== want.found)
               report_mismatch("found", 64'(want.found), 64'(rsp_found));
            if (rsp_best_class !== want.best_class)
               report_mismatch("best_class", 64'(want.best_class), 64'(rsp_best_class));
            if (rsp_best_distance !== want.best_distance)
               report_mismatch("best_distance", 64'(want.best_distance),
                               64'(rsp_best_distance));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Queries on an empty table, before and after a clear
   task automatic test_empty_table();
      send_item(ACT_QUERY, '0, '0, fill_vec(16'h8000));
      send_item(ACT_CLEAR, '1, '1, fill_vec(16'h7fff));
      send_item(ACT_QUERY, '1, '1, fill_vec(16'h7fff));
   endtask

   // Extreme slots, labels and element values, up to the largest distance
   task automatic test_extreme_values();
      send_item(ACT_LOAD, 6'd0, 4'd0, fill_vec(16'h8000));
      send_item(ACT_LOAD, 6'd63, 4'd15, fill_vec(16'h7fff));
      send_item(ACT_QUERY, '0, '0, fill_vec(16'h7fff));
      send_item(ACT_QUERY, '0, '0, fill_vec(16'h8000));
      send_item(ACT_QUERY, '0, '0, fill_vec(16'h0000));
      send_item(ACT_CLEAR, '0, '0, fill_vec(16'h0000));
      send_item(ACT_LOAD, 6'd0, 4'd9, fill_vec(16'h8000));
      send_item(ACT_QUERY, '1, '1, fill_vec(16'h7fff));
   endtask

   // Equal distances keep the lowest slot; an overwrite changes the winner
   task automatic test_tie_break();
      ncc_vec_type v;
      v = {16'h7fff, 16'h8000, 16'h0001, 16'hfedc, 16'h1234};
      send_item(ACT_CLEAR, '0, '0, v);
      send_item(ACT_LOAD, 6'd10, 4'd3, v);
      send_item(ACT_LOAD, 6'd4, 4'd7, v);
      send_item(ACT_LOAD, 6'd40, 4'd1, v);
      send_item(ACT_QUERY, '0, '0, v);
      send_item(ACT_QUERY, '0, '0, fill_vec(16'h0000));
      send_item(ACT_LOAD, 6'd4, 4'd2, fill_vec(16'h4000));
      send_item(ACT_QUERY, '0, '0, v);
   endtask

   // Unused action code leaves the table alone
   task automatic test_unused_action();
      send_item(ACT_UNUSED, '1, '1, rand_vec());
      send_item(ACT_QUERY, '0, '0, rand_vec());
   endtask

   // Episodes of loads then queries, with clears and noise mixed in
   task automatic test_random_traffic(input int unsigned quota, input int unsigned gap,
                                      input int unsigned stall);
      int unsigned goal;
      int unsigned n_loads;
      int unsigned n_queries;
      int          s;
      int          pick;
      ncc_vec_type v;
      gap_max   = gap;
      stall_pct = stall;
      goal      = items_sent + quota;
      while (items_sent < goal) begin
         if ($urandom_range(0, 2) == 0)
            send_item(ACT_CLEAR, SLOT_FLD_W'($urandom), LABEL_W'($urandom), rand_vec());
         // now and then fill every slot
         n_loads = ($urandom_range(0, 19) == 0) ? TABLE_SLOTS : $urandom_range(0, 8);
         for (int i = 0; i < n_loads; i++) begin
            s    = (n_loads == TABLE_SLOTS) ? i : $urandom_range(0, TABLE_SLOTS - 1);
            pick = find_live();
            // duplicate centroids make ties
            if (pick >= 0 && $urandom_range(0, 3) == 0) v = cent_vals[pick];
            else v = rand_vec();
            send_item(ACT_LOAD, SLOT_FLD_W'(s), LABEL_W'($urandom), v);
         end
         n_queries = $urandom_range(1, 6);
         for (int i = 0; i < n_queries; i++) begin
            pick = find_live();
            case ($urandom_range(0, 9))
               0: send_item(ACT_UNUSED, SLOT_FLD_W'($urandom), LABEL_W'($urandom),
                            rand_vec());
               1: send_item(ACT_LOAD, SLOT_FLD_W'($urandom), LABEL_W'($urandom),
                            rand_vec());
               default: ;
            endcase
            if (pick >= 0 && $urandom_range(0, 9) < 3) v = cent_vals[pick];
            else if (pick >= 0 && $urandom_range(0, 9) < 6) v = near_vec(cent_vals[pick]);
            else v = rand_vec();
            send_item(ACT_QUERY, SLOT_FLD_W'($urandom), LABEL_W'($urandom), v);
         end
      end
   endtask

   // Main sequence
   initial begin
      foreach (slot_live[s]) slot_live[s] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_extreme_values();
      test_tie_break();
      test_unused_action();
      test_random_traffic(400, 0, 0);
      test_random_traffic(650, 12, 35);
      test_random_traffic(580, 90, 70);
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
